// ===== rtl/pmfe_pkg.sv =====
package pmfe_pkg;

  localparam int QDEPTH = 2;
  localparam int QLW    = $clog2(QDEPTH + 1);

  localparam logic [2:0] CMD_STATUS = 3'd1;
  localparam logic [2:0] CMD_VOLT   = 3'd2;
  localparam logic [2:0] CMD_CURR   = 3'd3;
  localparam logic [2:0] CMD_POWER  = 3'd4;

  localparam int FLAG_RUN     = 0;
  localparam int FLAG_REST    = 1;
  localparam int FLAG_PATTERN = 2;
  localparam int FLAG_SLAVE   = 3;
  localparam int FLAG_PAIRED  = 4;

  localparam logic [7:0] ST_BASE   = 8'h04;
  localparam logic [7:0] ST_RUN    = 8'h08;
  localparam logic [7:0] ST_POS    = 8'h10;
  localparam logic [7:0] ST_NEG    = 8'h20;
  localparam logic [7:0] ST_LINK   = 8'h40;
  localparam logic [7:0] ST_REST_M = 8'hCF;

  localparam logic [7:0] CH_STX   = 8'h02;
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'h37;

  localparam logic [32:0] SAT_LIMIT = 33'd2000000000;

  typedef enum logic [1:0] {
    KIND_STATUS,
    KIND_VOLT,
    KIND_CURR,
    KIND_POWER
  } pmfe_kind_e;

  typedef struct packed {
    logic [3:0]         board;
    logic               channel;
    logic [2:0]         command;
    logic [4:0]         channel_flags;
    logic signed [31:0] current_prev;
    logic signed [31:0] current_own;
    logic signed [31:0] current_next;
    logic signed [31:0] voltage;
    logic signed [31:0] power_own;
    logic signed [31:0] power_next;
  } pmfe_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } pmfe_out_t;

  typedef struct packed {
    logic [3:0]  board;
    logic        channel;
    pmfe_kind_e  kind;
    logic [7:0]  status;
    logic        neg;
    logic [32:0] mag;
  } pmfe_job_t;

  typedef struct packed {
    logic [15:0][7:0] bytes;
    logic [3:0]       last_idx;
  } pmfe_frame_t;

endpackage

// ===== rtl/panel_meter_frame_encoder_core.sv =====
// channel  | direction | handshake                    | payload
// -------- | --------- | ---------------------------- | ----------
// command  | in        | start_i high, busy_o low     | item_i
// result   | out       | result_valid_o               | result_o
//
// Frame bytes leave one beat per cycle: 12 beats for a status frame, 16 for a
// value frame, back to back. The byte emitter sets the sustained snapshot rate;
// the decimal conversion (one digit per cycle) runs on the next snapshot while
// the current frame is sent.
// busy_o is high while the decode stage and the two-entry queue hold two jobs.
// rst_ni clears all control state; the receiver cannot stall results.
module panel_meter_frame_encoder_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  pmfe_pkg::pmfe_in_t  item_i,
  output logic                result_valid_o,
  output pmfe_pkg::pmfe_out_t result_o
);
  import pmfe_pkg::*;

  logic             push;
  pmfe_job_t        push_job;
  logic             q_valid, q_pop;
  pmfe_job_t        q_job;
  logic [QLW-1:0]   q_level;
  logic             frame_valid, frame_ready;
  pmfe_frame_t      frame;

  pmfe_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .item_i    (item_i),
    .q_level_i (q_level),
    .busy_o    (busy_o),
    .push_o    (push),
    .job_o     (push_job)
  );

  pmfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_job),
    .level_o (q_level)
  );

  pmfe_render u_render (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_job_i       (q_job),
    .q_pop_o       (q_pop),
    .frame_valid_o (frame_valid),
    .frame_ready_i (frame_ready),
    .frame_o       (frame)
  );

  pmfe_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_valid_i  (frame_valid),
    .frame_ready_o  (frame_ready),
    .frame_i        (frame),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

`ifndef SYNTHESIS
  a_full_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_level == QLW'(QDEPTH)) |-> busy_o)
    else $error("queue full but busy_o low");

  a_last_etx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_byte) |-> (result_o.frame_byte == CH_ETX))
    else $error("last beat is not ETX");

  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last_byte) |=> result_valid_o)
    else $error("gap inside a frame");

  a_first_stx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (!$past(result_valid_o) || $past(result_o.last_byte)))
      |-> (result_o.frame_byte == CH_STX))
    else $error("frame does not open with STX");
`endif

endmodule

// ===== rtl/pmfe_front.sv =====
module pmfe_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  pmfe_pkg::pmfe_in_t      item_i,
  input  logic [pmfe_pkg::QLW-1:0] q_level_i,
  output logic                    busy_o,
  output logic                    push_o,
  output pmfe_pkg::pmfe_job_t     job_o
);
  import pmfe_pkg::*;

  logic               run, rest, pat, slave, paired;
  logic signed [32:0] ip, io, inx, vv, po, pn;
  logic signed [32:0] sum_prev, sum_next, sum_pow;
  logic [7:0]         status_d;
  logic signed [32:0] val_d;
  logic               flip_d;
  logic               cmd_ok, accept;
  pmfe_kind_e         kind_d;

  logic               s1_v_q;
  logic [3:0]         board_q;
  logic               channel_q;
  pmfe_kind_e         kind_q;
  logic [7:0]         status_q;
  logic signed [32:0] val_q;
  logic               flip_q;

  assign run    = item_i.channel_flags[FLAG_RUN];
  assign rest   = item_i.channel_flags[FLAG_REST];
  assign pat    = item_i.channel_flags[FLAG_PATTERN];
  assign slave  = item_i.channel_flags[FLAG_SLAVE];
  assign paired = item_i.channel_flags[FLAG_PAIRED];

  assign ip  = 33'(item_i.current_prev);
  assign io  = 33'(item_i.current_own);
  assign inx = 33'(item_i.current_next);
  assign vv  = 33'(item_i.voltage);
  assign po  = 33'(item_i.power_own);
  assign pn  = 33'(item_i.power_next);

  assign sum_prev = ip + io;
  assign sum_next = io + inx;
  assign sum_pow  = po + pn;

  always_comb begin
    status_d = '0;
    if (run) begin
      status_d = ST_RUN;
      if (slave || paired) begin
        status_d = status_d | ST_LINK;
        if (slave) begin
          status_d = status_d | (sum_prev[32] ? ST_NEG : ST_POS);
        end
        if (paired) begin
          status_d = status_d | (sum_next[32] ? ST_NEG : ST_POS);
        end
      end else begin
        status_d = status_d | (io[32] ? ST_NEG : ST_POS);
      end
      if (rest) begin
        status_d = status_d & ST_REST_M;
      end
    end
    status_d = status_d | ST_BASE;
  end

  always_comb begin
    val_d  = '0;
    flip_d = 1'b0;
    kind_d = KIND_STATUS;
    cmd_ok = 1'b1;
    case (item_i.command)
      CMD_STATUS: begin
        kind_d = KIND_STATUS;
      end
      CMD_VOLT: begin
        kind_d = KIND_VOLT;
        val_d  = slave ? '0 : vv;
      end
      CMD_CURR: begin
        kind_d = KIND_CURR;
        if (run && !slave && !rest) begin
          val_d = paired ? sum_next : io;
        end
      end
      CMD_POWER: begin
        kind_d = KIND_POWER;
        if (run && !slave && !rest) begin
          val_d  = paired ? sum_pow : po;
          flip_d = paired && !pat && (io[32] || (io == '0));
        end
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
  end

  assign busy_o = ({1'b0, q_level_i} + (QLW + 1)'(s1_v_q)) >= (QLW + 1)'(QDEPTH);
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept && cmd_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      board_q   <= item_i.board;
      channel_q <= item_i.channel;
      kind_q    <= kind_d;
      status_q  <= status_d;
      val_q     <= val_d;
      flip_q    <= flip_d;
    end
  end

  // flipped sign: negative iff original is strictly positive
  assign push_o        = s1_v_q;
  assign job_o.board   = board_q;
  assign job_o.channel = channel_q;
  assign job_o.kind    = kind_q;
  assign job_o.status  = status_q;
  assign job_o.neg     = flip_q ? (!val_q[32] && (val_q != '0)) : val_q[32];
  assign job_o.mag     = val_q[32] ? 33'(-val_q) : 33'(val_q);

endmodule

// ===== rtl/pmfe_queue.sv =====
module pmfe_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  pmfe_pkg::pmfe_job_t      job_i,
  input  logic                     pop_i,
  output logic                     valid_o,
  output pmfe_pkg::pmfe_job_t      job_o,
  output logic [pmfe_pkg::QLW-1:0] level_o
);
  import pmfe_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  pmfe_job_t       mem_q [QDEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [QLW-1:0]  cnt_q;
  logic            do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign level_o = cnt_q;
  assign do_push = push_i && (cnt_q != QLW'(QDEPTH));
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

// ===== rtl/pmfe_render.sv =====
module pmfe_render (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  pmfe_pkg::pmfe_job_t   q_job_i,
  output logic                  q_pop_o,
  output logic                  frame_valid_o,
  input  logic                  frame_ready_i,
  output pmfe_pkg::pmfe_frame_t frame_o
);
  import pmfe_pkg::*;

  typedef enum logic [1:0] {
    R_IDLE,
    R_CONV,
    R_HOLD
  } state_e;

  state_e         state_q;
  pmfe_job_t      job_q;
  logic           sat_q;
  logic [30:0]    rem_q;
  logic [2:0]     k_q;
  logic [7:0][3:0] dig_q;

  logic [3:0]     digit;
  logic [33:0]    sub;
  logic           is_value;

  // j * 10^(k+2)
  function automatic logic [33:0] place_mul(input logic [2:0] k, input logic [3:0] j);
    logic [33:0] base;
    case (k)
      3'd0:    base = 34'd100;
      3'd1:    base = 34'd1000;
      3'd2:    base = 34'd10000;
      3'd3:    base = 34'd100000;
      3'd4:    base = 34'd1000000;
      3'd5:    base = 34'd10000000;
      3'd6:    base = 34'd100000000;
      3'd7:    base = 34'd1000000000;
      default: base = 34'd0;
    endcase
    return 34'(base * {30'd0, j});
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (CH_ZERO + {4'd0, n}) : (HEX_ALPHA_OFS + {4'd0, n});
  endfunction

  function automatic logic [7:0] dchar(input logic [3:0] d);
    return CH_ZERO + {4'd0, d};
  endfunction

  function automatic logic [7:0] rchar(input logic [3:0] d, input logic [3:0] nxt);
    return ((nxt >= 4'd5) && (d < 4'd9)) ? dchar(d + 4'd1) : dchar(d);
  endfunction

  always_comb begin
    digit = '0;
    sub   = '0;
    for (int j = 1; j < 10; j++) begin
      if ({3'd0, rem_q} >= place_mul(k_q, 4'(j))) begin
        digit = 4'(j);
        sub   = place_mul(k_q, 4'(j));
      end
    end
  end

  assign q_pop_o       = (state_q == R_IDLE) && q_valid_i;
  assign frame_valid_o = (state_q == R_HOLD);
  assign is_value      = (job_q.kind != KIND_STATUS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      job_q   <= '0;
      sat_q   <= 1'b0;
      rem_q   <= '0;
      k_q     <= '0;
      dig_q   <= '0;
    end else begin
      case (state_q)
        R_IDLE: begin
          if (q_valid_i) begin
            job_q <= q_job_i;
            sat_q <= (q_job_i.mag >= SAT_LIMIT);
            rem_q <= q_job_i.mag[30:0];
            k_q   <= 3'd7;
            if ((q_job_i.kind == KIND_STATUS) || (q_job_i.mag >= SAT_LIMIT)) begin
              state_q <= R_HOLD;
            end else begin
              state_q <= R_CONV;
            end
          end
        end
        R_CONV: begin
          dig_q <= {dig_q[6:0], digit};
          rem_q <= rem_q - sub[30:0];
          if (k_q == 3'd0) begin
            state_q <= R_HOLD;
          end else begin
            k_q <= k_q - 3'd1;
          end
        end
        R_HOLD: begin
          if (frame_ready_i) begin
            state_q <= R_IDLE;
          end
        end
        default: begin
          state_q <= R_IDLE;
        end
      endcase
    end
  end

  // dig_q[7] holds the 1e9 digit, dig_q[0] the 1e2 digit
  always_comb begin
    logic [10:1][7:0] body;
    logic [15:0]      sum;
    body     = '0;
    body[1]  = CH_ZERO;
    body[2]  = CH_ZERO + {4'd0, job_q.board};
    body[3]  = CH_ZERO + {7'd0, job_q.channel};
    if (!is_value) begin
      body[4] = CH_ZERO;
      body[5] = hex_char(job_q.status[7:4]);
      body[6] = hex_char(job_q.status[3:0]);
    end else begin
      case (job_q.kind)
        KIND_VOLT: body[4] = CH_ZERO + 8'd1;
        KIND_CURR: body[4] = CH_ZERO + 8'd2;
        default:   body[4] = CH_ZERO + 8'd3;
      endcase
      body[5] = job_q.neg ? CH_MINUS : CH_SPACE;
      if (sat_q) begin
        body[6]  = CH_F;
        body[7]  = CH_F;
        body[8]  = CH_F;
        body[9]  = CH_F;
        body[10] = CH_F;
      end else if (dig_q[7] != '0) begin
        body[6]  = dchar(dig_q[7]);
        body[7]  = dchar(dig_q[6]);
        body[8]  = dchar(dig_q[5]);
        body[9]  = rchar(dig_q[4], dig_q[3]);
        body[10] = CH_DOT;
      end else if (dig_q[6] != '0) begin
        body[6]  = dchar(dig_q[6]);
        body[7]  = dchar(dig_q[5]);
        body[8]  = dchar(dig_q[4]);
        body[9]  = CH_DOT;
        body[10] = rchar(dig_q[3], dig_q[2]);
      end else if (dig_q[5] != '0) begin
        body[6]  = dchar(dig_q[5]);
        body[7]  = dchar(dig_q[4]);
        body[8]  = CH_DOT;
        body[9]  = dchar(dig_q[3]);
        body[10] = rchar(dig_q[2], dig_q[1]);
      end else begin
        body[6]  = dchar(dig_q[4]);
        body[7]  = CH_DOT;
        body[8]  = dchar(dig_q[3]);
        body[9]  = dchar(dig_q[2]);
        body[10] = rchar(dig_q[1], dig_q[0]);
      end
    end

    sum = '0;
    for (int i = 1; i <= 10; i++) begin
      sum = sum + {8'd0, body[i]};
    end

    frame_o.bytes    = '0;
    frame_o.bytes[0] = CH_STX;
    for (int i = 1; i <= 10; i++) begin
      frame_o.bytes[i] = body[i];
    end
    if (!is_value) begin
      frame_o.bytes[7]  = hex_char(sum[15:12]);
      frame_o.bytes[8]  = hex_char(sum[11:8]);
      frame_o.bytes[9]  = hex_char(sum[7:4]);
      frame_o.bytes[10] = hex_char(sum[3:0]);
      frame_o.bytes[11] = CH_ETX;
      frame_o.last_idx  = 4'd11;
    end else begin
      frame_o.bytes[11] = hex_char(sum[15:12]);
      frame_o.bytes[12] = hex_char(sum[11:8]);
      frame_o.bytes[13] = hex_char(sum[7:4]);
      frame_o.bytes[14] = hex_char(sum[3:0]);
      frame_o.bytes[15] = CH_ETX;
      frame_o.last_idx  = 4'd15;
    end
  end

endmodule

// ===== rtl/pmfe_emit.sv =====
module pmfe_emit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  frame_valid_i,
  output logic                  frame_ready_o,
  input  pmfe_pkg::pmfe_frame_t frame_i,
  output logic                  result_valid_o,
  output pmfe_pkg::pmfe_out_t   result_o
);
  import pmfe_pkg::*;

  logic             active_q;
  logic [3:0]       cnt_q;
  logic [15:0][7:0] bytes_q;
  logic             load;

  assign frame_ready_o = !active_q || (cnt_q == '0);
  assign load          = frame_valid_i && frame_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else if (load) begin
      active_q <= 1'b1;
      cnt_q    <= frame_i.last_idx;
    end else if (active_q) begin
      if (cnt_q == '0) begin
        active_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bytes_q <= frame_i.bytes;
    end else if (active_q) begin
      bytes_q <= {8'h00, bytes_q[15:1]};
    end
  end

  assign result_valid_o      = active_q;
  assign result_o.frame_byte = bytes_q[0];
  assign result_o.last_byte  = active_q && (cnt_q == '0);

endmodule
